@@ src/gdsw_pkg.sv @@
`default_nettype none

package gdsw_pkg;

   localparam int MAX_YEAR = 9999;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int SERIAL_W = 22;
   localparam int DIFF_W   = 23;
   localparam int WDAY_W   = 3;
   localparam int MLEN_W   = 5;
   localparam int CUM_W    = 9;
   localparam int QUAD_W   = YEAR_W - 2;
   localparam int CENT_W   = $clog2(MAX_YEAR / 100 + 1);

   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTH_JAN     = 1;
   localparam int MONTH_FEB     = 2;
   localparam int MONTH_DEC     = 12;

   // floor(x / 25) as (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 4096
   localparam int DIV25_MUL   = 1311;
   localparam int DIV25_SHIFT = 15;
   localparam int DIV25_W     = 12;
   // floor(x / 7) as (x * DIV7_MUL) >> DIV7_SHIFT, exact for x below 2**22
   localparam int DIV7_MUL    = 4793491;
   localparam int DIV7_SHIFT  = 25;
   localparam int DIV7_W      = 23;

   localparam int NUM_DATES = 2;

   typedef struct packed {
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [SERIAL_W-1:0] p365;
      logic [QUAD_W-1:0]   p4;
      logic [CENT_W-1:0]   p100;
      logic [QUAD_W-1:0]   y4;
      logic [CENT_W-1:0]   y100;
      logic [1:0]          ylo;
   } s1_type;

   typedef struct packed {
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic                leap;
      logic [SERIAL_W-1:0] dyear;
   } s2_type;

   typedef struct packed {
      logic [WDAY_W-1:0] xlo;
      logic [WDAY_W-1:0] qlo;
   } wd_type;

   function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] r;
      r = y;
      if (y == '0)
         r = YEAR_W'(1);
      else if (y > YEAR_W'(MAX_YEAR))
         r = YEAR_W'(MAX_YEAR);
      return r;
   endfunction

   function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] r;
      r = m;
      if (m < MONTH_W'(MONTH_JAN))
         r = MONTH_W'(MONTH_JAN);
      else if (m > MONTH_W'(MONTH_DEC))
         r = MONTH_W'(MONTH_DEC);
      return r;
   endfunction

   // days before the first of a month in a common year
   function automatic logic [CUM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [CUM_W-1:0] r;
      unique case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m);
      logic [MLEN_W-1:0] r;
      unique case (m)
         4'd2:    r = 5'd28;
         4'd4:    r = 5'd30;
         4'd6:    r = 5'd30;
         4'd9:    r = 5'd30;
         4'd11:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/gdsw_if.sv @@
`default_nettype none

interface gdsw_req_if;
   import gdsw_pkg::*;

   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year_a;
   logic [MONTH_W-1:0] month_a;
   logic [DAY_W-1:0]   day_a;
   logic [YEAR_W-1:0]  year_b;
   logic [MONTH_W-1:0] month_b;
   logic [DAY_W-1:0]   day_b;

   modport source (
      output valid, year_a, month_a, day_a, year_b, month_b, day_b,
      input  ready
   );
   modport sink (
      input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
      output ready
   );
endinterface

interface gdsw_rsp_if;
   import gdsw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SERIAL_W-1:0]      serial_a;
   logic [SERIAL_W-1:0]      serial_b;
   logic signed [DIFF_W-1:0] diff_days;
   logic [WDAY_W-1:0]        weekday_a;
   logic [WDAY_W-1:0]        weekday_b;
   logic [MLEN_W-1:0]        month_length_a;
   logic [WDAY_W-1:0]        first_weekday_a;

   modport source (
      output valid, serial_a, serial_b, diff_days, weekday_a, weekday_b,
             month_length_a, first_weekday_a,
      input  ready
   );
   modport sink (
      input  valid, serial_a, serial_b, diff_days, weekday_a, weekday_b,
             month_length_a, first_weekday_a,
      output ready
   );
endinterface

`default_nettype wire

@@ src/gregorian_date_serial_and_weekday.sv @@
// Date pair to day number and weekday unit.
// req_chan carries two calendar dates (year, month, day each); rsp_chan
// returns both day numbers (0001-01-01 is day 1), the signed difference
// B minus A, both weekdays (0 Monday .. 6 Sunday), the length of A's month
// and the weekday of the first of A's month.
// A transaction moves on each channel at a clock edge with valid and ready
// both high. Out-of-range years and months are clamped; days are not checked.
// rsp valid rises once the req transaction has passed through all stages,
// and a stall on rsp_chan can hold it back longer. The work runs in
// five register stages (year terms, leap and year sum, month offset,
// reciprocal divide by 7, remainder and difference), so one transaction is
// taken every cycle while rsp_chan.ready stays high.
// Each stage holds its own valid bit; when rsp_chan.ready is low the full
// stages hold their data and empty stages ahead still fill, so req_chan.ready
// drops only once all five stages are full. Nothing is dropped or repeated.
// A synchronous reset clears all stage valid bits; the block takes a
// transaction in the first cycle after reset.
`default_nettype none

module gregorian_date_serial_and_weekday (
   input  wire logic   clock,
   input  wire logic   reset,
   gdsw_req_if.sink    req_chan,
   gdsw_rsp_if.source  rsp_chan
);
   import gdsw_pkg::*;

   localparam int NUM_STAGES = 5;

   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] vld_in;
   logic [NUM_STAGES:1] rdy;

   s1_type s1_in [NUM_DATES];
   s1_type s1_ff [NUM_DATES];
   s2_type s2_in [NUM_DATES];
   s2_type s2_ff [NUM_DATES];

   logic [SERIAL_W-1:0] s3_serial_in [NUM_DATES];
   logic [SERIAL_W-1:0] s3_serial_ff [NUM_DATES];
   logic [SERIAL_W-1:0] s3_base_a_in;
   logic [SERIAL_W-1:0] s3_base_a_ff;
   logic [MLEN_W-1:0]   s3_mlen_in;
   logic [MLEN_W-1:0]   s3_mlen_ff;

   logic [SERIAL_W-1:0] s4_serial_ff [NUM_DATES];
   logic [MLEN_W-1:0]   s4_mlen_ff;
   wd_type              s4_wd_in [3];
   wd_type              s4_wd_ff [3];

   logic [SERIAL_W-1:0]      s5_serial_ff [NUM_DATES];
   logic signed [DIFF_W-1:0] s5_diff_in;
   logic signed [DIFF_W-1:0] s5_diff_ff;
   logic [WDAY_W-1:0]        s5_wd_in [3];
   logic [WDAY_W-1:0]        s5_wd_ff [3];
   logic [MLEN_W-1:0]        s5_mlen_ff;

   logic [YEAR_W-1:0]  in_year  [NUM_DATES];
   logic [MONTH_W-1:0] in_month [NUM_DATES];
   logic [DAY_W-1:0]   in_day   [NUM_DATES];

   // handshake: a stage loads when it is empty or its contents move on
   always_comb begin
      rdy[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = req_chan.valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_chan.ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: clamp, years before, quarter and century counts
   always_comb begin
      in_year[0]  = req_chan.year_a;
      in_month[0] = req_chan.month_a;
      in_day[0]   = req_chan.day_a;
      in_year[1]  = req_chan.year_b;
      in_month[1] = req_chan.month_b;
      in_day[1]   = req_chan.day_b;
      for (int i = 0; i < NUM_DATES; i++) begin
         logic [YEAR_W-1:0]       yc;
         logic [YEAR_W-1:0]       p;
         logic [QUAD_W-1:0]       p4;
         logic [QUAD_W-1:0]       y4;
         logic [DIV25_W+QUAD_W-1:0] mp;
         logic [DIV25_W+QUAD_W-1:0] my;
         yc = clamp_year(in_year[i]);
         p  = yc - YEAR_W'(1);
         p4 = p[YEAR_W-1:2];
         y4 = yc[YEAR_W-1:2];
         mp = (DIV25_W+QUAD_W)'(p4) * (DIV25_W+QUAD_W)'(DIV25_MUL);
         my = (DIV25_W+QUAD_W)'(y4) * (DIV25_W+QUAD_W)'(DIV25_MUL);
         s1_in[i].month = clamp_month(in_month[i]);
         s1_in[i].day   = in_day[i];
         s1_in[i].p365  = SERIAL_W'(p) * SERIAL_W'(DAYS_PER_YEAR);
         s1_in[i].p4    = p4;
         s1_in[i].p100  = CENT_W'(mp >> DIV25_SHIFT);
         s1_in[i].y4    = y4;
         s1_in[i].y100  = CENT_W'(my >> DIV25_SHIFT);
         s1_in[i].ylo   = yc[1:0];
      end
   end

   // stage 2: leap flag and days before the year
   always_comb begin
      for (int i = 0; i < NUM_DATES; i++) begin
         logic century;
         century = (s1_ff[i].y4 == QUAD_W'(s1_ff[i].y100) * QUAD_W'(25));
         s2_in[i].month = s1_ff[i].month;
         s2_in[i].day   = s1_ff[i].day;
         s2_in[i].leap  = (s1_ff[i].ylo == 2'b00) &&
                          (!century || (s1_ff[i].y100[1:0] == 2'b00));
         s2_in[i].dyear = s1_ff[i].p365 + SERIAL_W'(s1_ff[i].p4)
                          - SERIAL_W'(s1_ff[i].p100)
                          + SERIAL_W'(s1_ff[i].p100 >> 2);
      end
   end

   // stage 3: month offset and day, and the length of A's month
   always_comb begin
      logic [SERIAL_W-1:0] base [NUM_DATES];
      for (int i = 0; i < NUM_DATES; i++) begin
         logic [CUM_W-1:0] cum;
         cum = days_before_month(s2_ff[i].month)
               + CUM_W'(s2_ff[i].leap && (s2_ff[i].month > MONTH_W'(MONTH_FEB)));
         base[i]         = s2_ff[i].dyear + SERIAL_W'(cum);
         s3_serial_in[i] = base[i] + SERIAL_W'(s2_ff[i].day);
      end
      s3_base_a_in = base[0];
      s3_mlen_in   = month_days(s2_ff[0].month)
                     + MLEN_W'(s2_ff[0].leap && (s2_ff[0].month == MONTH_W'(MONTH_FEB)));
   end

   // stage 4: quotient by 7 through a reciprocal multiply
   always_comb begin
      logic [SERIAL_W-1:0] x [3];
      x[0] = s3_serial_ff[0] + SERIAL_W'(6);
      x[1] = s3_serial_ff[1] + SERIAL_W'(6);
      x[2] = s3_base_a_ff + SERIAL_W'(7);
      for (int j = 0; j < 3; j++) begin
         logic [SERIAL_W+DIV7_W-1:0] prod;
         prod = (SERIAL_W+DIV7_W)'(x[j]) * (SERIAL_W+DIV7_W)'(DIV7_MUL);
         s4_wd_in[j].xlo = x[j][WDAY_W-1:0];
         s4_wd_in[j].qlo = prod[DIV7_SHIFT+WDAY_W-1:DIV7_SHIFT];
      end
   end

   // stage 5: x - 7q equals x + q modulo 8, and the remainder is below 7
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s5_wd_in[j] = s4_wd_ff[j].xlo + s4_wd_ff[j].qlo;
      end
      s5_diff_in = DIFF_W'({1'b0, s4_serial_ff[1]}) - DIFF_W'({1'b0, s4_serial_ff[0]});
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_ff <= s1_in;
      end
      if (rdy[2]) begin
         s2_ff <= s2_in;
      end
      if (rdy[3]) begin
         s3_serial_ff <= s3_serial_in;
         s3_base_a_ff <= s3_base_a_in;
         s3_mlen_ff   <= s3_mlen_in;
      end
      if (rdy[4]) begin
         s4_serial_ff <= s3_serial_ff;
         s4_mlen_ff   <= s3_mlen_ff;
         s4_wd_ff     <= s4_wd_in;
      end
      if (rdy[5]) begin
         s5_serial_ff <= s4_serial_ff;
         s5_diff_ff   <= s5_diff_in;
         s5_wd_ff     <= s5_wd_in;
         s5_mlen_ff   <= s4_mlen_ff;
      end
   end

   assign rsp_chan.valid           = vld_ff[NUM_STAGES];
   assign rsp_chan.serial_a        = s5_serial_ff[0];
   assign rsp_chan.serial_b        = s5_serial_ff[1];
   assign rsp_chan.diff_days       = s5_diff_ff;
   assign rsp_chan.weekday_a       = s5_wd_ff[0];
   assign rsp_chan.weekday_b       = s5_wd_ff[1];
   assign rsp_chan.first_weekday_a = s5_wd_ff[2];
   assign rsp_chan.month_length_a  = s5_mlen_ff;

`ifndef NO_ASSERTIONS
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.weekday_a != 3'd7) && (rsp_chan.weekday_b != 3'd7)
                         && (rsp_chan.first_weekday_a != 3'd7))
      else $error("weekday remainder out of range");

   a_month_length: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.month_length_a >= 5'd28)
                         && (rsp_chan.month_length_a <= 5'd31))
      else $error("month length out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] && !rdy[2] |=> vld_ff[1])
      else $error("stalled first stage lost its transaction");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> req_chan.ready)
      else $error("empty pipeline refuses a transaction");
`endif

endmodule

`default_nettype wire

@@ dv/gregorian_date_serial_and_weekday_tb.sv @@
`timescale 1ns / 1ps

module gregorian_date_serial_and_weekday_tb;
   import gdsw_pkg::*;

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct {
      logic [SERIAL_W-1:0]      serial_a;
      logic [SERIAL_W-1:0]      serial_b;
      logic signed [DIFF_W-1:0] diff_days;
      logic [WDAY_W-1:0]        weekday_a;
      logic [WDAY_W-1:0]        weekday_b;
      logic [MLEN_W-1:0]        month_length_a;
      logic [WDAY_W-1:0]        first_weekday_a;
   } day_numbers_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   error_count = 0;
   int   rsp_count = 0;

   int unsigned common_month_len [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   day_numbers_type day_number_queue [$];

   gdsw_req_if req_bus ();
   gdsw_rsp_if rsp_bus ();

   gregorian_date_serial_and_weekday dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_len(int unsigned y, int unsigned m);
      if (m == MONTH_FEB && is_leap(y))
         return 29;
      return common_month_len[m];
   endfunction

   // days before the first of month m of year y
   function automatic int unsigned days_to_month(int unsigned y, int unsigned m);
      int unsigned p;
      int unsigned d;
      p = y - 1;
      d = p * DAYS_PER_YEAR + p / 4 - p / 100 + p / 400;
      for (int unsigned i = 1; i < m; i++)
         d += month_len(y, i);
      return d;
   endfunction

   function automatic day_numbers_type calc_day_numbers(date_type a, date_type b);
      day_numbers_type r;
      int unsigned  y_a;
      int unsigned  m_a;
      int unsigned  y_b;
      int unsigned  m_b;
      int unsigned  base_a;
      int unsigned  sa;
      int unsigned  sb;
      y_a = (a.year == 0) ? 1 : (a.year > MAX_YEAR) ? MAX_YEAR : int'(a.year);
      y_b = (b.year == 0) ? 1 : (b.year > MAX_YEAR) ? MAX_YEAR : int'(b.year);
      m_a = (a.month < MONTH_JAN) ? MONTH_JAN : (a.month > MONTH_DEC) ? MONTH_DEC
            : int'(a.month);
      m_b = (b.month < MONTH_JAN) ? MONTH_JAN : (b.month > MONTH_DEC) ? MONTH_DEC
            : int'(b.month);
      base_a = days_to_month(y_a, m_a);
      sa = base_a + a.day;
      sb = days_to_month(y_b, m_b) + b.day;
      r.serial_a        = SERIAL_W'(sa);
      r.serial_b        = SERIAL_W'(sb);
      r.diff_days       = DIFF_W'(longint'(sb) - longint'(sa));
      r.weekday_a       = WDAY_W'((sa + 6) % 7);
      r.weekday_b       = WDAY_W'((sb + 6) % 7);
      r.month_length_a  = MLEN_W'(month_len(y_a, m_a));
      r.first_weekday_a = WDAY_W'((base_a + 7) % 7);
      return r;
   endfunction

   task automatic flag_mismatch(string msg);
      error_count++;
      $display("mismatch at %0t, response %0d: %s", $time, rsp_count, msg);
   endtask

   // accepted requests feed the predictor, accepted responses are checked
   always @(posedge clock) begin
      date_type        a;
      date_type        b;
      day_numbers_type got;
      day_numbers_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            a = '{req_bus.year_a, req_bus.month_a, req_bus.day_a};
            b = '{req_bus.year_b, req_bus.month_b, req_bus.day_b};
            day_number_queue = {day_number_queue, calc_day_numbers(a, b)};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.serial_a        = rsp_bus.serial_a;
            got.serial_b        = rsp_bus.serial_b;
            got.diff_days       = rsp_bus.diff_days;
            got.weekday_a       = rsp_bus.weekday_a;
            got.weekday_b       = rsp_bus.weekday_b;
            got.month_length_a  = rsp_bus.month_length_a;
            got.first_weekday_a = rsp_bus.first_weekday_a;
            if (day_number_queue.size() == 0) begin
               flag_mismatch("response transaction with nothing pending");
            end else begin
               want = day_number_queue.pop_front();
               if (got.serial_a !== want.serial_a)
                  flag_mismatch($sformatf("serial_a %0d, want %0d",
                                          got.serial_a, want.serial_a));
               if (got.serial_b !== want.serial_b)
                  flag_mismatch($sformatf("serial_b %0d, want %0d",
                                          got.serial_b, want.serial_b));
               if (got.diff_days !== want.diff_days)
                  flag_mismatch($sformatf("diff_days %0d, want %0d",
                                          got.diff_days, want.diff_days));
               if (got.weekday_a !== want.weekday_a)
                  flag_mismatch($sformatf("weekday_a %0d, want %0d",
                                          got.weekday_a, want.weekday_a));
               if (got.weekday_b !== want.weekday_b)
                  flag_mismatch($sformatf("weekday_b %0d, want %0d",
                                          got.weekday_b, want.weekday_b));
               if (got.month_length_a !== want.month_length_a)
                  flag_mismatch($sformatf("month_length_a %0d, want %0d",
                                          got.month_length_a, want.month_length_a));
               if (got.first_weekday_a !== want.first_weekday_a)
                  flag_mismatch($sformatf("first_weekday_a %0d, want %0d",
                                          got.first_weekday_a, want.first_weekday_a));
            end
            rsp_count++;
         end
      end
   end

   always @(posedge clock)
      rsp_bus.ready <= steady || ($urandom_range(99) >= 21);

   task automatic send_dates(int unsigned ya, int unsigned ma, int unsigned da,
                             int unsigned yb, int unsigned mb, int unsigned db);
      while (!steady && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.year_a  <= YEAR_W'(ya);
      req_bus.month_a <= MONTH_W'(ma);
      req_bus.day_a   <= DAY_W'(da);
      req_bus.year_b  <= YEAR_W'(yb);
      req_bus.month_b <= MONTH_W'(mb);
      req_bus.day_b   <= DAY_W'(db);
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   function automatic date_type pick_date();
      date_type    d;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         // raw bits, out-of-range fields included
         d.year  = YEAR_W'($urandom);
         d.month = MONTH_W'($urandom);
         d.day   = DAY_W'($urandom);
      end else begin
         if (roll < 18)
            d.year = YEAR_W'($urandom_range(4, 1));
         else if (roll < 24)
            d.year = YEAR_W'(MAX_YEAR - $urandom_range(3, 0));
         else if (roll < 36)
            d.year = YEAR_W'($urandom_range(99, 1) * 100);
         else
            d.year = YEAR_W'($urandom_range(MAX_YEAR, 1));
         d.month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
         d.day   = DAY_W'($urandom_range(month_len(d.year, d.month), 1));
      end
      return d;
   endfunction

   task automatic test_extremes();
      send_dates(1, 1, 1, 9999, 12, 31);
      send_dates(9999, 12, 31, 1, 1, 1);
      send_dates(9999, 12, 31, 9999, 12, 31);
   endtask

   task automatic test_clamping();
      send_dates(0, 0, 1, 16383, 15, 31);
      send_dates(10000, 13, 15, 0, 5, 10);
      send_dates(9999, 15, 0, 1, 0, 0);
      send_dates(12345, 12, 31, 10000, 1, 1);
      send_dates(0, 14, 16, 8191, 0, 1);
   endtask

   task automatic test_odd_days();
      send_dates(2023, 4, 31, 2023, 5, 1);
      send_dates(2023, 2, 29, 2024, 2, 29);
      send_dates(2024, 3, 0, 2023, 3, 0);
      send_dates(2023, 2, 31, 2023, 12, 31);
   endtask

   task automatic test_leap_rules();
      send_dates(1900, 2, 28, 2000, 2, 29);
      send_dates(2100, 2, 1, 2400, 2, 1);
      send_dates(2024, 2, 15, 2023, 2, 15);
      send_dates(1600, 3, 1, 1700, 3, 1);
      send_dates(4, 2, 29, 100, 2, 28);
   endtask

   // one full week, ending on a sunday whose serial is a multiple of 7
   task automatic test_weekdays();
      for (int unsigned d = 1; d <= 7; d++)
         send_dates(1, 1, d, 2024, 1, d);
   endtask

   task automatic test_random_dates(int count);
      date_type a;
      date_type b;
      for (int n = 0; n < count; n++) begin
         steady = (n < count / 5);
         a = pick_date();
         b = pick_date();
         if ($urandom_range(3) == 0)
            b.year = a.year;
         send_dates(a.year, a.month, a.day, b.year, b.month, b.day);
      end
      steady = 1'b0;
   endtask

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.year_a  <= '0;
      req_bus.month_a <= '0;
      req_bus.day_a   <= '0;
      req_bus.year_b  <= '0;
      req_bus.month_b <= '0;
      req_bus.day_b   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_clamping();
      test_odd_days();
      test_leap_rules();
      test_weekdays();
      test_random_dates(1600);
      req_bus.valid <= 1'b0;

      while (day_number_queue.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
